[rtl/brfb_pkg.sv]
`default_nettype none
package brfb_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 4096;

  localparam int unsigned CNT_W  = 13;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 3;

  // Capacity after reset, before any clamp to the store depth
  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;
  // Largest capacity the 13-bit register can express
  localparam int unsigned CAP_FIELD_MAX = 8191;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_NO_ROOM = 3'd2,
    ST_NO_DATA = 3'd3,
    ST_DROPPED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    K_FLUSH = 4'b0001,
    K_NOP   = 4'b0010,
    K_FIRST = 4'b0100,
    K_CONT  = 4'b1000
  } kind_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    kind_t             kind;
    logic              is_deq;
    logic [DATA_W-1:0] din;
    logic [CNT_W-1:0]  len;
    logic              len_zero;
    logic              len_over;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic [CNT_W-1:0]  readable;
    logic [CNT_W-1:0]  writable;
  } res_t;

endpackage
`default_nettype wire

[rtl/brfb_ram.sv]
`default_nettype none
module brfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/brfb_front.sv]
`default_nettype none
module brfb_front
  import brfb_pkg::*;
(
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [DATA_W-1:0] din,
  input  wire logic [CNT_W-1:0]  len,
  input  wire logic              first,
  input  wire logic [CNT_W-1:0]  cap,
  input  wire logic              q_full,
  output      logic              q_push,
  output      item_t             q_item
);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_item.is_deq   = (op_t'(op) == OP_DEQ);
    q_item.din      = din;
    q_item.len      = len;
    q_item.len_zero = (len == '0);
    q_item.len_over = (len > cap);
    case (op_t'(op))
      OP_FLUSH: q_item.kind = K_FLUSH;
      OP_RSVD:  q_item.kind = K_NOP;
      OP_ENQ,
      OP_DEQ:   q_item.kind = first ? K_FIRST : K_CONT;
      default:  q_item.kind = K_NOP;
    endcase
  end

endmodule
`default_nettype wire

[rtl/brfb_queue.sv]
`default_nettype none
module brfb_queue
  import brfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  valid,
  output      item_t head
);

  item_t       slot [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/brfb_back.sv]
`default_nettype none
module brfb_back
  import brfb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  output      logic [CNT_W-1:0] cap,
  input  wire logic             q_valid,
  input  wire item_t            q_item,
  output      logic             q_pop,
  output      logic             m_valid,
  input  wire logic             m_ready,
  output      res_t             m_res
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned XW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int unsigned CAP_LIMIT =
    (STORE_DEPTH < CAP_FIELD_MAX) ? STORE_DEPTH : CAP_FIELD_MAX;
  localparam logic [CNT_W-1:0] CAP_LIMIT_V = CAP_LIMIT[CNT_W-1:0];
  localparam logic [CNT_W-1:0] CAP_INIT =
    (CAP_RESET > CAP_LIMIT_V) ? CAP_LIMIT_V : CAP_RESET;

  typedef enum logic [1:0] {
    S_EXEC    = 2'b01,
    S_CAPTURE = 2'b10
  } state_t;

  state_t            state;
  logic [AW-1:0]     wpos, wpos_next;
  logic [AW-1:0]     rpos, rpos_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [CNT_W-1:0]  bleft, bleft_next;
  logic              brej, brej_next;
  logic              bdeq, bdeq_next;
  logic [CNT_W-1:0]  room;
  logic              put_ok, get_ok;
  logic              do_wr, do_rd;
  status_t           stat;
  logic              exec;
  logic [DATA_W-1:0] rdata;

  // Result fields waiting for the registered RAM read
  status_t           p_status;
  logic              p_valid;
  logic [CNT_W-1:0]  p_readable;
  logic [CNT_W-1:0]  p_writable;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                            input logic [CNT_W-1:0] c);
    logic [XW-1:0] n;
    n = XW'(p) + XW'(1);
    return (n >= XW'(c)) ? '0 : n[AW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v;
    if (v == '0) c = CNT_W'(1);
    if (v > CAP_LIMIT_V) c = CAP_LIMIT_V;
    return c;
  endfunction

  assign exec   = (state == S_EXEC) && q_valid && (!m_valid || m_ready);
  assign q_pop  = exec;
  assign room   = cap - fill;
  assign put_ok = (fill < cap);
  assign get_ok = (fill != '0);

  always_comb begin
    wpos_next  = wpos;
    rpos_next  = rpos;
    fill_next  = fill;
    bleft_next = bleft;
    brej_next  = brej;
    bdeq_next  = bdeq;
    stat       = ST_OK;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    case (q_item.kind)
      K_FLUSH: begin
        bleft_next = '0;
        brej_next  = 1'b0;
        bdeq_next  = 1'b0;
      end
      K_NOP: begin
        stat = ST_DROPPED;
      end
      K_FIRST: begin
        bdeq_next  = q_item.is_deq;
        bleft_next = q_item.len_zero ? '0 : q_item.len - CNT_W'(1);
        if (!q_item.is_deq) begin
          if (q_item.len_zero || q_item.len_over) stat = ST_BAD_LEN;
          else if (q_item.len > room)            stat = ST_NO_ROOM;
          else if (!put_ok)                      stat = ST_NO_ROOM;
          else                                   do_wr = 1'b1;
        end else if (!q_item.len_zero) begin
          if (q_item.len > fill) stat = ST_NO_DATA;
          else if (!get_ok)      stat = ST_NO_DATA;
          else                   do_rd = 1'b1;
        end
        brej_next = (stat != ST_OK);
      end
      K_CONT: begin
        if (bleft == '0) begin
          stat = ST_DROPPED;
        end else begin
          bleft_next = bleft - CNT_W'(1);
          if (brej || (q_item.is_deq != bdeq)) stat = ST_DROPPED;
          else if (!q_item.is_deq) begin
            if (put_ok) do_wr = 1'b1;
            else        stat = ST_NO_ROOM;
          end else begin
            if (get_ok) do_rd = 1'b1;
            else        stat = ST_NO_DATA;
          end
        end
      end
      default: stat = ST_DROPPED;
    endcase
    if (do_wr) begin
      wpos_next = advance(wpos, cap);
      fill_next = fill + CNT_W'(1);
    end
    if (do_rd) begin
      rpos_next = advance(rpos, cap);
      fill_next = fill - CNT_W'(1);
    end
    if (q_item.kind == K_FLUSH) begin
      wpos_next = '0;
      rpos_next = '0;
      fill_next = '0;
    end
  end

  brfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (exec && do_wr),
    .waddr (wpos),
    .wdata (q_item.din),
    .re    (exec && do_rd),
    .raddr (rpos),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_INIT;
      wpos  <= '0;
      rpos  <= '0;
      fill  <= '0;
      bleft <= '0;
      brej  <= 1'b0;
      bdeq  <= 1'b0;
    end else if (cfg_we) begin
      // new capacity empties the ring and drops any open block
      cap   <= clamp_cap(cfg_wdata);
      wpos  <= '0;
      rpos  <= '0;
      fill  <= '0;
      bleft <= '0;
      brej  <= 1'b0;
      bdeq  <= 1'b0;
    end else if (exec) begin
      wpos  <= wpos_next;
      rpos  <= rpos_next;
      fill  <= fill_next;
      bleft <= bleft_next;
      brej  <= brej_next;
      bdeq  <= bdeq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      p_status   <= stat;
      p_valid    <= do_rd;
      p_readable <= fill_next;
      p_writable <= cap - fill_next;
    end
    if (state == S_CAPTURE) begin
      m_res.status     <= p_status;
      m_res.data_out   <= p_valid ? rdata : '0;
      m_res.data_valid <= p_valid;
      m_res.readable   <= p_readable;
      m_res.writable   <= p_writable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_EXEC;
      m_valid <= 1'b0;
    end else begin
      case (state)
        S_EXEC: begin
          if (m_valid && m_ready) m_valid <= 1'b0;
          if (exec) state <= S_CAPTURE;
        end
        S_CAPTURE: begin
          m_valid <= 1'b1;
          state   <= S_EXEC;
        end
        default: state <= S_EXEC;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/byte_ring_fifo_block_admission.sv]
`default_nettype none
// Byte ring FIFO with whole-block admission. Each input transfer carries one
// byte operation (enqueue, dequeue, flush) and yields exactly one result
// transfer with status, the dequeued byte and the readable and writable counts
// after the operation. A block is admitted or rejected on its first item;
// bytes of a rejected block come back with status dropped. Items pass a
// two-entry queue into the execution unit, which handles each item in an
// execute state (pointer update and byte RAM access), then a capture state
// (registered read data into the output register). No new item is taken
// before the last one is captured, nor while a result waits on m_tready. The
// byte RAM needs no clearing after reset, so items are accepted once reset is
// released. Writing cfg_wdata (capacity, clamped to 1..min(STORE_DEPTH, 8191))
// empties the FIFO and must only happen while the block is idle.
module byte_ring_fifo_block_admission
  import brfb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  input  wire logic [23:0]      s_tdata,   // opcode[1:0], data_in[9:2], block_length[22:10]
  input  wire logic             s_tuser,   // first_of_block
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  output      logic [39:0]      m_tdata,   // status[2:0], data_out[10:3],
                                           // readable_count[23:11], writable_count[36:24]
  output      logic             m_tuser    // data_valid
);

  logic [CNT_W-1:0] cap;
  logic             q_full;
  logic             q_push;
  item_t            q_in;
  logic             q_valid;
  logic             q_pop;
  item_t            q_head;
  res_t             res;

  brfb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tdata[1:0]),
    .din      (s_tdata[9:2]),
    .len      (s_tdata[22:10]),
    .first    (s_tuser),
    .cap      (cap),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  brfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  brfb_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cap       (cap),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_res     (res)
  );

  assign m_tdata = {3'b000, res.writable, res.readable, res.data_out, res.status};
  assign m_tuser = res.data_valid;

endmodule
`default_nettype wire

[dv/byte_ring_fifo_block_admission_tb.sv]
`timescale 1ns / 100ps

module byte_ring_fifo_block_admission_tb;
  import brfb_pkg::*;

  typedef struct {
    op_t op;
    logic [7:0] din;
    logic [12:0] len;
    logic first;
  } ring_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;   // opcode[1:0], data_in[9:2], block_length[22:10]
  logic s_tuser = 1'b0;        // first_of_block
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[2:0], data_out[10:3],
                               // readable_count[23:11], writable_count[36:24]
  logic m_tuser;               // data_valid

  byte_ring_fifo_block_admission dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow ring state
  logic [7:0] ring_bytes [0:4095];
  int unsigned wr_pos = 0;
  int unsigned rd_pos = 0;
  int unsigned held = 0;
  int unsigned blk_left = 0;
  bit blk_dropped = 1'b0;
  bit blk_is_read = 1'b0;
  logic [12:0] cap_reg = CAP_RESET;

  ring_item_t items_to_send[$];
  res_t fifo_replies_due[$];

  int mismatches = 0;
  int transfers_in = 0;
  int bytes_read = 0;
  int cap_writes = 0;
  int status_seen [0:4];
  bit item_taken = 1'b0;
  bit steady = 1'b0;
  int send_gap = 0;
  int sink_gap = 0;

  function automatic int unsigned usable_cap(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return {19'd0, v};
  endfunction

  function automatic status_t store_byte(input logic [7:0] b, input int unsigned lim);
    if (held >= lim) return ST_NO_ROOM;
    ring_bytes[wr_pos[11:0]] = b;
    wr_pos = (wr_pos + 1 >= lim) ? 0 : wr_pos + 1;
    held++;
    return ST_OK;
  endfunction

  function automatic status_t fetch_byte(input int unsigned lim, output logic [7:0] b);
    b = '0;
    if (held == 0) return ST_NO_DATA;
    b = ring_bytes[rd_pos[11:0]];
    rd_pos = (rd_pos + 1 >= lim) ? 0 : rd_pos + 1;
    held--;
    return ST_OK;
  endfunction

  task automatic empty_ring();
    wr_pos = 0;
    rd_pos = 0;
    held = 0;
    blk_left = 0;
    blk_dropped = 1'b0;
    blk_is_read = 1'b0;
  endtask

  task automatic ring_predict(input ring_item_t it, output res_t r);
    int unsigned lim;
    status_t st;
    logic [7:0] b;
    lim = usable_cap(cap_reg);
    st = ST_OK;
    b = '0;
    r = '0;
    if (it.op == OP_FLUSH) begin
      empty_ring();
    end else if (it.op == OP_RSVD) begin
      st = ST_DROPPED;
    end else if (it.first) begin
      blk_is_read = (it.op == OP_DEQ);
      blk_left = (it.len > 0) ? it.len - 1 : 0;
      blk_dropped = 1'b0;
      if (it.op == OP_ENQ) begin
        if (it.len == 0 || it.len > lim) st = ST_BAD_LEN;
        else if (it.len > lim - held) st = ST_NO_ROOM;
        else st = store_byte(it.din, lim);
      end else if (it.len > 0) begin
        if (it.len > held) st = ST_NO_DATA;
        else begin
          st = fetch_byte(lim, b);
          r.data_valid = (st == ST_OK);
        end
      end
      if (st != ST_OK) blk_dropped = 1'b1;
    end else if (blk_left == 0) begin
      st = ST_DROPPED;
    end else begin
      blk_left--;
      if (blk_dropped || ((it.op == OP_DEQ) != blk_is_read)) begin
        st = ST_DROPPED;
      end else if (it.op == OP_ENQ) begin
        st = store_byte(it.din, lim);
      end else begin
        st = fetch_byte(lim, b);
        r.data_valid = (st == ST_OK);
      end
    end
    r.status = st;
    r.data_out = b;
    r.readable = 13'(held);
    r.writable = 13'(lim - held);
  endtask

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Driver: advance to the next item once the current transfer has happened
  always @(negedge clk) begin : driver
    ring_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
      // hold until accepted
    end else if (send_gap != 0) begin
      s_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (items_to_send.size() != 0) begin
      nxt = items_to_send.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= {1'b0, nxt.len, nxt.din, nxt.op};
      s_tuser <= nxt.first;
      send_gap <= pick_gap();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 20) sink_gap <= pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    ring_item_t seen;
    res_t want;
    item_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.op = op_t'(s_tdata[1:0]);
        seen.din = s_tdata[9:2];
        seen.len = s_tdata[22:10];
        seen.first = s_tuser;
        ring_predict(seen, want);
        fifo_replies_due.push_back(want);
        transfers_in++;
        status_seen[want.status]++;
        if (want.data_valid) bytes_read++;
      end
      if (m_tvalid && m_tready) begin
        if (fifo_replies_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual 0x%h", $time, m_tdata);
          mismatches++;
        end else begin
          want = fifo_replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
          check_field("data_out", 32'(want.data_out), 32'(m_tdata[10:3]));
          check_field("data_valid", 32'(want.data_valid), 32'(m_tuser));
          check_field("readable_count", 32'(want.readable), 32'(m_tdata[23:11]));
          check_field("writable_count", 32'(want.writable), 32'(m_tdata[36:24]));
        end
      end
    end
  end

  task automatic push_item(input op_t op, input logic [7:0] d, input logic [12:0] len,
                           input logic first);
    ring_item_t it;
    it.op = op;
    it.din = d;
    it.len = len;
    it.first = first;
    items_to_send.push_back(it);
  endtask

  task automatic wait_drained();
    while (items_to_send.size() != 0 || s_tvalid || fifo_replies_due.size() != 0)
      @(posedge clk);
  endtask

  // Only while idle: drain, let the pipeline settle, then write
  task automatic write_capacity(input logic [12:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cap_reg = v;
    empty_ring();
    cap_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed blocks with random content; some noise and broken blocks
  task automatic queue_block_traffic(input int n, input int unsigned lim);
    int made, len, nsend, k, p;
    op_t op, op_k;
    made = 0;
    while (made < n) begin
      p = $urandom_range(0, 99);
      if (p < 3) begin
        push_item(OP_FLUSH, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 4096)),
                  1'($urandom_range(0, 1)));
        made++;
      end else if (p < 5) begin
        push_item(OP_RSVD, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 4096)),
                  1'($urandom_range(0, 1)));
        made++;
      end else if (p < 8) begin
        push_item($urandom_range(0, 1) ? OP_DEQ : OP_ENQ, 8'($urandom_range(0, 255)),
                  13'($urandom_range(0, 4096)), 1'b0);
        made++;
      end else begin
        op = ($urandom_range(0, 99) < 55) ? OP_ENQ : OP_DEQ;
        p = $urandom_range(0, 99);
        if (p < 70) len = $urandom_range(1, (lim < 8) ? lim : 8);
        else if (p < 85) len = $urandom_range(1, (lim < 64) ? lim : 64);
        else if (p < 90) len = 0;
        else if (p < 95 && lim < 4096)
          len = $urandom_range(lim + 1, (lim + 8 > 4096) ? 4096 : lim + 8);
        else len = $urandom_range(4095, 4096);
        nsend = (len == 0) ? 1 : len;
        p = $urandom_range(0, 99);
        // cut long blocks short: the next first item abandons them
        if (nsend > 64 || p < 8) nsend = $urandom_range(1, (nsend < 6) ? nsend : 6);
        else if (p < 12) nsend++;
        for (k = 0; k < nsend; k++) begin
          op_k = op;
          if (k > 0 && $urandom_range(0, 99) < 3) op_k = (op == OP_ENQ) ? OP_DEQ : OP_ENQ;
          push_item(op_k, 8'($urandom_range(0, 255)),
                    (k == 0) ? 13'(len) : 13'($urandom_range(0, 4096)), k == 0);
        end
        made += nsend;
      end
    end
  endtask

  task automatic run_phase(input logic [12:0] cap_value, input int n);
    int quiet, c;
    write_capacity(cap_value);
    quiet = $urandom_range(0, 3);
    for (c = 0; c < 4; c++) begin
      steady = (c == quiet);
      queue_block_traffic(n / 4, usable_cap(cap_value));
      while (items_to_send.size() != 0) @(posedge clk);
      if (c == 1) wait_drained();
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: stray items, zero lengths, abandoned and mixed blocks, flush
    push_item(OP_ENQ, 8'h12, 13'd0, 1'b0);
    push_item(OP_RSVD, 8'h34, 13'd5, 1'b1);
    push_item(OP_ENQ, 8'h56, 13'd0, 1'b1);
    push_item(OP_DEQ, 8'h00, 13'd0, 1'b1);
    push_item(OP_DEQ, 8'h00, 13'd3, 1'b1);
    push_item(OP_DEQ, 8'h00, 13'd0, 1'b0);
    push_item(OP_ENQ, 8'hFF, 13'd4096, 1'b1);
    push_item(OP_ENQ, 8'h00, 13'd2, 1'b1);
    push_item(OP_ENQ, 8'hAA, 13'd4096, 1'b0);
    push_item(OP_DEQ, 8'h00, 13'd2, 1'b1);
    push_item(OP_ENQ, 8'h77, 13'd0, 1'b0);
    push_item(OP_FLUSH, 8'h00, 13'd0, 1'b0);
    push_item(OP_ENQ, 8'h55, 13'd4095, 1'b1);
    push_item(OP_FLUSH, 8'h00, 13'd7, 1'b1);

    // Zero capacity behaves as one byte
    write_capacity(13'd0);
    push_item(OP_ENQ, 8'h3C, 13'd1, 1'b1);
    push_item(OP_ENQ, 8'h11, 13'd1, 1'b1);
    push_item(OP_ENQ, 8'h22, 13'd2, 1'b1);
    push_item(OP_ENQ, 8'h33, 13'd0, 1'b0);
    push_item(OP_DEQ, 8'h00, 13'd1, 1'b1);
    push_item(OP_DEQ, 8'h00, 13'd1, 1'b1);
    push_item(OP_ENQ, 8'hC3, 13'd1, 1'b1);
    push_item(OP_DEQ, 8'h00, 13'd1, 1'b1);

    run_phase(13'd16, 300);
    run_phase(13'd1, 200);
    run_phase(13'd8191, 300);
    run_phase(13'd5, 250);
    run_phase(13'd300, 300);
    run_phase(13'd4096, 300);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fifo_replies_due.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, fifo_replies_due.size(), fifo_replies_due.size());
      mismatches++;
    end
    $display("Sent %0d transfers over %0d capacity writes; %0d bytes came back out",
             transfers_in, cap_writes, bytes_read);
    $display("Status mix: ok %0d, bad length %0d, no room %0d, no data %0d, dropped %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("byte_ring_fifo_block_admission verification clean");
    end else begin
      $display("byte_ring_fifo_block_admission verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("byte_ring_fifo_block_admission verification failed");
    $finish;
  end

endmodule
